### src/xmt_pkg.sv
// ============================================================================
// xmt_pkg - shared types and constants of the XML markup tokenizer
// Parse phase codes, byte roles, event codes and the beat structs.
// ============================================================================
`default_nettype none

package xmt_pkg;

    localparam int unsigned POSITION_BITS_DEF = 32;

    typedef logic [4:0] t_phase;

    localparam t_phase PH_START      = 5'd0;
    localparam t_phase PH_OPEN       = 5'd1;
    localparam t_phase PH_CONTENT    = 5'd2;
    localparam t_phase PH_CHARDATA   = 5'd3;
    localparam t_phase PH_LT         = 5'd4;
    localparam t_phase PH_DECL_XML   = 5'd5;
    localparam t_phase PH_DECL_SPACE = 5'd6;
    localparam t_phase PH_DECL_AFTER = 5'd7;
    localparam t_phase PH_DECL_Q     = 5'd8;
    localparam t_phase PH_TAG_SPACE  = 5'd9;
    localparam t_phase PH_EMPTY_GT   = 5'd10;
    localparam t_phase PH_ETAG_SPACE = 5'd11;
    localparam t_phase PH_DONE       = 5'd12;
    localparam t_phase PH_NAME_BASE  = 5'd13;
    localparam t_phase PH_ATTR_BASE  = 5'd21;
    localparam t_phase PH_ATTR_END   = 5'd29;

    // name contexts
    localparam logic [1:0] CTX_ELEM      = 2'd0;
    localparam logic [1:0] CTX_TAG_ATTR  = 2'd1;
    localparam logic [1:0] CTX_DECL_ATTR = 2'd2;
    localparam logic [1:0] CTX_ETAG      = 2'd3;

    localparam logic [2:0] ROLE_MARKUP = 3'd0;
    localparam logic [2:0] ROLE_PREFIX = 3'd1;
    localparam logic [2:0] ROLE_NAME   = 3'd2;
    localparam logic [2:0] ROLE_VALUE  = 3'd3;
    localparam logic [2:0] ROLE_CHAR   = 3'd4;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_DECL    = 3'd1;
    localparam logic [2:0] EV_START   = 3'd2;
    localparam logic [2:0] EV_EMPTY   = 3'd3;
    localparam logic [2:0] EV_END     = 3'd4;
    localparam logic [2:0] EV_CONTENT = 3'd5;

    typedef struct packed {
        t_phase     phase;
        logic       quote_dbl;
        logic [1:0] decl_stage;
        logic       err;
    } t_state;

    typedef struct packed {
        logic [2:0] role;
        logic       token_first;
        logic [2:0] event_done;
    } t_cls;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_stream;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [31:0] byte_offset;
        logic [2:0]  role;
        logic        token_first;
        logic [2:0]  event_done;
        logic        error;
        logic        stream_done;
    } t_out_beat;

endpackage

`default_nettype wire

### src/xmt_classify.sv
// ============================================================================
// xmt_classify - per-byte classifier
// Combinational next-state and role/event logic for one byte or end of stream.
// A byte may re-dispatch through a few phases in the same cycle.
// ============================================================================
`default_nettype none

module xmt_classify (
    input  wire xmt_pkg::t_state i_state,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_eos,
    output xmt_pkg::t_state      o_state,
    output xmt_pkg::t_cls        o_cls
);

    // longest chain: open -> name -> tag space -> attr name -> attr '='
    localparam int unsigned STEP_MAX = 5;

    typedef struct packed {
        xmt_pkg::t_state st;
        logic            again;
        xmt_pkg::t_cls   cls;
    } t_step;

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h20;
    endfunction

    function automatic logic ends_name(input logic [7:0] c);
        return is_space(c) || c == "/" || c == "?" || c == "=" || c == ">";
    endfunction

    function automatic xmt_pkg::t_phase name_follow(input logic [1:0] ctx);
        xmt_pkg::t_phase p;
        unique case (ctx)
            xmt_pkg::CTX_ELEM:      p = xmt_pkg::PH_TAG_SPACE;
            xmt_pkg::CTX_TAG_ATTR:  p = xmt_pkg::PH_ATTR_BASE;
            xmt_pkg::CTX_DECL_ATTR: p = xmt_pkg::PH_ATTR_BASE + 5'd4;
            default:                p = xmt_pkg::PH_ETAG_SPACE;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] xml_char(input logic [1:0] ds);
        logic [7:0] ch;
        unique case (ds)
            2'd0:    ch = "x";
            2'd1:    ch = "m";
            default: ch = "l";
        endcase
        return ch;
    endfunction

    function automatic t_step step(input xmt_pkg::t_state s, input logic [7:0] c);
        t_step           r;
        xmt_pkg::t_phase off;
        xmt_pkg::t_phase base;
        logic [1:0]      ctx;
        logic [1:0]      k;
        logic            actx;
        logic [7:0]      q;
        r.st      = s;
        r.again   = 1'b0;
        r.cls     = '{role: xmt_pkg::ROLE_MARKUP, token_first: 1'b0,
                      event_done: xmt_pkg::EV_NONE};
        off  = '0;
        base = '0;
        ctx  = '0;
        k    = '0;
        actx = 1'b0;
        q    = s.quote_dbl ? 8'h22 : 8'h27;
        if (s.phase >= xmt_pkg::PH_NAME_BASE && s.phase < xmt_pkg::PH_ATTR_BASE) begin
            off = s.phase - xmt_pkg::PH_NAME_BASE;
            ctx = off[2:1];
            if (ends_name(c)) begin
                r.st.phase = name_follow(ctx);
                r.again    = 1'b1;
            end else if (c == ":") begin
                r.cls.role = xmt_pkg::ROLE_PREFIX;
                r.st.phase = xmt_pkg::PH_NAME_BASE + 5'({ctx, 1'b0});
            end else begin
                r.cls.role        = xmt_pkg::ROLE_NAME;
                r.cls.token_first = ~off[0];
                r.st.phase        = xmt_pkg::PH_NAME_BASE + 5'({ctx, 1'b1});
            end
        end else if (s.phase >= xmt_pkg::PH_ATTR_BASE && s.phase < xmt_pkg::PH_ATTR_END) begin
            off  = s.phase - xmt_pkg::PH_ATTR_BASE;
            actx = off[2];
            k    = off[1:0];
            base = xmt_pkg::PH_ATTR_BASE + 5'({actx, 2'b00});
            if (k == 2'd0) begin
                if (c == "=") r.st.phase = base + 5'd1;
                else if (!is_space(c)) r.st.err = 1'b1;
            end else if (k == 2'd1) begin
                if (c == 8'h27 || c == 8'h22) begin
                    r.st.quote_dbl = (c == 8'h22);
                    r.st.phase     = base + 5'd2;
                end else if (!is_space(c)) begin
                    r.st.err = 1'b1;
                end
            end else begin
                if (c == "&" || c == "<") begin
                    r.st.err = 1'b1;
                end else if (c == q) begin
                    r.st.phase = actx ? xmt_pkg::PH_DECL_AFTER : xmt_pkg::PH_TAG_SPACE;
                end else begin
                    r.cls.role        = xmt_pkg::ROLE_VALUE;
                    r.cls.token_first = (k == 2'd2);
                    r.st.phase        = base + 5'd3;
                end
            end
        end else begin
            unique case (s.phase)
                xmt_pkg::PH_START: begin
                    if (c == "<") r.st.phase = xmt_pkg::PH_OPEN;
                    else r.st.err = 1'b1;
                end
                xmt_pkg::PH_OPEN: begin
                    if (c == "?") begin
                        r.st.decl_stage = 2'd0;
                        r.st.phase      = xmt_pkg::PH_DECL_XML;
                    end else begin
                        r.st.phase = xmt_pkg::PH_NAME_BASE;
                        r.again    = 1'b1;
                    end
                end
                xmt_pkg::PH_CONTENT: begin
                    if (c == "<") begin
                        r.st.phase = xmt_pkg::PH_LT;
                    end else begin
                        r.cls.role        = xmt_pkg::ROLE_CHAR;
                        r.cls.token_first = 1'b1;
                        r.st.phase        = xmt_pkg::PH_CHARDATA;
                    end
                end
                xmt_pkg::PH_CHARDATA: begin
                    if (c == "<") begin
                        r.cls.event_done = xmt_pkg::EV_CONTENT;
                        r.st.phase       = xmt_pkg::PH_LT;
                    end else begin
                        r.cls.role = xmt_pkg::ROLE_CHAR;
                    end
                end
                xmt_pkg::PH_LT: begin
                    if (c == "/") begin
                        r.st.phase = xmt_pkg::PH_NAME_BASE + 5'({xmt_pkg::CTX_ETAG, 1'b0});
                    end else if (c == "!" || c == "?") begin
                        r.st.err = 1'b1;
                    end else begin
                        r.st.phase = xmt_pkg::PH_NAME_BASE;
                        r.again    = 1'b1;
                    end
                end
                xmt_pkg::PH_DECL_XML: begin
                    if (s.decl_stage != 2'd3 && c == xml_char(s.decl_stage)) begin
                        if (s.decl_stage == 2'd2) begin
                            r.st.decl_stage = 2'd0;
                            r.st.phase      = xmt_pkg::PH_DECL_SPACE;
                        end else begin
                            r.st.decl_stage = s.decl_stage + 2'd1;
                        end
                    end else begin
                        r.st.err = 1'b1;
                    end
                end
                xmt_pkg::PH_DECL_SPACE: begin
                    if (!is_space(c)) begin
                        r.st.phase = xmt_pkg::PH_NAME_BASE
                                   + 5'({xmt_pkg::CTX_DECL_ATTR, 1'b0});
                        r.again    = 1'b1;
                    end
                end
                xmt_pkg::PH_DECL_AFTER: begin
                    priority if (is_space(c)) begin
                        r.st = s;
                    end else if (c == "e" && s.decl_stage == 2'd0) begin
                        r.st.decl_stage = 2'd1;
                        r.st.phase      = xmt_pkg::PH_NAME_BASE
                                        + 5'({xmt_pkg::CTX_DECL_ATTR, 1'b0});
                        r.again         = 1'b1;
                    end else if (c == "s" && s.decl_stage <= 2'd1) begin
                        r.st.decl_stage = 2'd2;
                        r.st.phase      = xmt_pkg::PH_NAME_BASE
                                        + 5'({xmt_pkg::CTX_DECL_ATTR, 1'b0});
                        r.again         = 1'b1;
                    end else if (c == "?") begin
                        r.st.phase = xmt_pkg::PH_DECL_Q;
                    end else begin
                        r.st.err = 1'b1;
                    end
                end
                xmt_pkg::PH_DECL_Q: begin
                    if (c == ">") begin
                        r.cls.event_done = xmt_pkg::EV_DECL;
                        r.st.phase       = xmt_pkg::PH_CONTENT;
                    end else begin
                        r.st.err = 1'b1;
                    end
                end
                xmt_pkg::PH_TAG_SPACE: begin
                    priority if (is_space(c)) begin
                        r.st = s;
                    end else if (c == "/") begin
                        r.st.phase = xmt_pkg::PH_EMPTY_GT;
                    end else if (c == ">") begin
                        r.cls.event_done = xmt_pkg::EV_START;
                        r.st.phase       = xmt_pkg::PH_CONTENT;
                    end else begin
                        r.st.phase = xmt_pkg::PH_NAME_BASE
                                   + 5'({xmt_pkg::CTX_TAG_ATTR, 1'b0});
                        r.again    = 1'b1;
                    end
                end
                xmt_pkg::PH_EMPTY_GT: begin
                    if (c == ">") begin
                        r.cls.event_done = xmt_pkg::EV_EMPTY;
                        r.st.phase       = xmt_pkg::PH_CONTENT;
                    end else begin
                        r.st.err = 1'b1;
                    end
                end
                xmt_pkg::PH_ETAG_SPACE: begin
                    priority if (is_space(c)) begin
                        r.st = s;
                    end else if (c == ">") begin
                        r.cls.event_done = xmt_pkg::EV_END;
                        r.st.phase       = xmt_pkg::PH_CONTENT;
                    end else begin
                        r.st.err = 1'b1;
                    end
                end
                default: begin
                    r.st = s;
                end
            endcase
        end
        return r;
    endfunction

    xmt_pkg::t_state cur;
    xmt_pkg::t_cls   cls;
    t_step           stp;
    logic            go;
    logic            eos_err;

    always_comb begin
        cur     = i_state;
        cls     = '{role: xmt_pkg::ROLE_MARKUP, token_first: 1'b0,
                    event_done: xmt_pkg::EV_NONE};
        stp     = '0;
        go      = 1'b1;
        eos_err = !(i_state.phase == xmt_pkg::PH_START
                    || i_state.phase == xmt_pkg::PH_OPEN
                    || i_state.phase == xmt_pkg::PH_CONTENT
                    || i_state.phase == xmt_pkg::PH_LT
                    || i_state.phase == xmt_pkg::PH_DONE)
                  && i_state.phase < xmt_pkg::PH_ATTR_END;
        if (i_eos) begin
            if (!i_state.err) begin
                if (i_state.phase == xmt_pkg::PH_CHARDATA) begin
                    cls.event_done = xmt_pkg::EV_CONTENT;
                end else if (eos_err) begin
                    cur.err = 1'b1;
                end
            end
            cur.phase = xmt_pkg::PH_DONE;
        end else begin
            // re-dispatch the same byte while a phase hands it on
            for (int i = 0; i < STEP_MAX; i++) begin
                if (go && !cur.err) begin
                    stp = step(cur, i_byte);
                    cur = stp.st;
                    cls = stp.cls;
                    go  = stp.again;
                end else begin
                    go = 1'b0;
                end
            end
        end
        if (cur.err) begin
            cls = '{role: xmt_pkg::ROLE_MARKUP, token_first: 1'b0,
                    event_done: xmt_pkg::EV_NONE};
        end
    end

    assign o_state = cur;
    assign o_cls   = cls;

endmodule

`default_nettype wire

### src/xml_markup_tokenizer_unit.sv
// Each result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one byte per cycle; the single output register is refilled in
// the cycle it drains, so input ready drops only while the output is stalled.
// Reset (synchronous, active low) returns the parser to document start, clears
// the sticky error, the byte position and the output valid.
// ============================================================================
// xml_markup_tokenizer_unit - streaming XML byte classifier
// Gives one result beat per input beat: byte role, token start, completed
// event, sticky error and end-of-stream marker.
// ============================================================================
`default_nettype none

module xml_markup_tokenizer_unit #(
    parameter int unsigned POSITION_BITS = xmt_pkg::POSITION_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire xmt_pkg::t_in_beat i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output xmt_pkg::t_out_beat     o_out_data
);

    xmt_pkg::t_state          r_state;
    xmt_pkg::t_state          n_state;
    xmt_pkg::t_cls            n_cls;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] n_pos;
    logic                     r_out_valid;
    xmt_pkg::t_out_beat       r_out;
    xmt_pkg::t_out_beat       n_out;
    logic                     accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    xmt_classify u_classify (
        .i_state (r_state),
        .i_byte  (i_in_data.byte_in),
        .i_eos   (i_in_data.end_of_stream),
        .o_state (n_state),
        .o_cls   (n_cls)
    );

    // end of stream does not advance the position
    assign n_pos = i_in_data.end_of_stream ? r_pos : r_pos + 1'b1;

    always_comb begin
        n_out.byte_out    = i_in_data.end_of_stream ? 8'h00 : i_in_data.byte_in;
        n_out.byte_offset = 32'(r_pos);
        n_out.role        = n_cls.role;
        n_out.token_first = n_cls.token_first;
        n_out.event_done  = n_cls.event_done;
        n_out.error       = n_state.err;
        n_out.stream_done = i_in_data.end_of_stream;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{phase: xmt_pkg::PH_START, quote_dbl: 1'b0,
                             decl_stage: 2'd0, err: 1'b0};
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_pos       <= n_pos;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // sticky error never clears outside reset
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.err |=> r_state.err)
        else $error("error flag cleared");

    // an erroneous beat carries no role, token start or event
    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.error |->
            o_out_data.role == xmt_pkg::ROLE_MARKUP && !o_out_data.token_first
            && o_out_data.event_done == xmt_pkg::EV_NONE)
        else $error("role or event reported after error");

    // a token start is never a markup byte
    a_first_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.token_first |->
            o_out_data.role != xmt_pkg::ROLE_MARKUP)
        else $error("token start on markup byte");

    // end-of-stream beat carries no byte and no role
    a_eos_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.stream_done |->
            o_out_data.byte_out == 8'h00 && o_out_data.role == xmt_pkg::ROLE_MARKUP)
        else $error("end-of-stream beat carries data");

    // a stalled output beat holds its valid and bumps nothing
    a_stall_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(r_pos))
        else $error("position advanced while output stalled");

endmodule

`default_nettype wire
